### hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 32;
   localparam int ACC_W     = 64;
   localparam int OPCODE_W  = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // payload length limit after reset, 10 MiB
   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd10485760;

   // seven-bit length codes that announce an extended length
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   // number of extended length bytes
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } item_kind_type;

   // one result item
   typedef struct packed {
      item_kind_type       item_kind;
      logic                final_fragment;
      logic [OPCODE_W-1:0] frame_opcode;
      logic                was_masked;
      logic [LEN_W-1:0]    frame_length;
      logic [BYTE_W-1:0]   data_byte;
      logic                last_of_frame;
   } rsp_item_type;

endpackage

### hdl/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_req_if / wsd_rsp_if
// Valid/ready channels for the received byte stream and the result items.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic                       valid;
   logic                       ready;
   logic [wsd_pkg::BYTE_W-1:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   item_kind;
   logic                         final_fragment;
   logic [wsd_pkg::OPCODE_W-1:0] frame_opcode;
   logic                         was_masked;
   logic [wsd_pkg::LEN_W-1:0]    frame_length;
   logic [wsd_pkg::BYTE_W-1:0]   data_byte;
   logic                         last_of_frame;

   modport source (output valid, output item_kind, output final_fragment,
                   output frame_opcode, output was_masked, output frame_length,
                   output data_byte, output last_of_frame, input ready);
   modport sink   (input valid, input item_kind, input final_fragment,
                   input frame_opcode, input was_masked, input frame_length,
                   input data_byte, input last_of_frame, output ready);
endinterface

### hdl/wsd_csr.sv
// ----------------------------------------------------------------------------
// wsd_csr
// APB-style register port holding the payload length limit.
// ----------------------------------------------------------------------------
module wsd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wsd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wsd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [wsd_pkg::LEN_W-1:0]       max_len
);
   import wsd_pkg::*;

   // register index, taken from the word address bit
   localparam logic REG_MAX_PAYLOAD = 1'b0;

   logic             wr_en;
   logic             sel_max;
   logic [LEN_W-1:0] max_len_ff;
   logic [LEN_W-1:0] max_len_in;

   assign csr_pready = 1'b1;
   assign sel_max    = (csr_paddr[CSR_ADDR_W-1] == REG_MAX_PAYLOAD);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // limit register
   always_comb begin
      max_len_in = max_len_ff;
      if (wr_en && sel_max) begin
         max_len_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // read back
   assign csr_prdata = sel_max ? max_len_ff : '0;
   assign max_len    = max_len_ff;

endmodule

### hdl/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Header and payload parser: one byte per cycle while in_fire is high, at most one result per byte.
// ----------------------------------------------------------------------------
module wsd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_fire,
   input  logic [wsd_pkg::BYTE_W-1:0]  in_byte,
   input  logic [wsd_pkg::LEN_W-1:0]   max_len,
   output logic                        res_valid,
   output wsd_pkg::rsp_item_type       res_item
);
   import wsd_pkg::*;

   typedef enum logic [5:0] {
      PH_BYTE0   = 6'b000001,
      PH_BYTE1   = 6'b000010,
      PH_EXTLEN  = 6'b000100,
      PH_KEY     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_ERROR   = 6'b100000
   } phase_type;

   phase_type           phase_ff,  phase_in;
   logic                fin_ff,    fin_in;
   logic [OPCODE_W-1:0] opcode_ff, opcode_in;
   logic                masked_ff, masked_in;
   logic [ACC_W-1:0]    acc_ff,    acc_in;
   logic [3:0]          len_left_ff, len_left_in;
   logic [31:0]         key_ff,    key_in;
   logic [1:0]          key_idx_ff, key_idx_in;
   logic [LEN_W-1:0]    pay_left_ff, pay_left_in;

   logic [6:0]          len7;
   logic [ACC_W-1:0]    acc_shift;
   logic [31:0]         key_shift;
   logic [1:0]          key_idx_inc;
   logic [BYTE_W-1:0]   key_byte;
   logic                len_done;
   logic [ACC_W-1:0]    len_value;
   logic                hdr_done;
   logic [LEN_W-1:0]    hdr_len;
   logic                over;

   assign len7        = in_byte[6:0];
   assign acc_shift   = {acc_ff[ACC_W-BYTE_W-1:0], in_byte};
   assign key_shift   = {key_ff[23:0], in_byte};
   assign key_idx_inc = key_idx_ff + 2'd1;

   // key byte for the current payload position, first key byte in the top
   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // length check against the limit
   assign over = (len_value > {{(ACC_W-LEN_W){1'b0}}, max_len});

   // next state and result
   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      masked_in   = masked_ff;
      acc_in      = acc_ff;
      len_left_in = len_left_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      pay_left_in = pay_left_ff;
      len_done    = 1'b0;
      len_value   = acc_ff;
      hdr_done    = 1'b0;
      hdr_len     = acc_ff[LEN_W-1:0];
      res_valid   = 1'b0;
      res_item    = '0;

      unique case (phase_ff)
         PH_BYTE0: begin
            fin_in    = in_byte[7];
            opcode_in = in_byte[OPCODE_W-1:0];
            phase_in  = PH_BYTE1;
         end
         PH_BYTE1: begin
            masked_in = in_byte[7];
            acc_in    = '0;
            if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
               len_left_in = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in    = PH_EXTLEN;
            end else begin
               acc_in    = {{(ACC_W-7){1'b0}}, len7};
               len_value = {{(ACC_W-7){1'b0}}, len7};
               len_done  = 1'b1;
            end
         end
         PH_EXTLEN: begin
            acc_in      = acc_shift;
            len_left_in = len_left_ff - 4'd1;
            len_value   = acc_shift;
            len_done    = (len_left_ff == 4'd1);
         end
         PH_KEY: begin
            key_in     = key_shift;
            key_idx_in = key_idx_inc;
            hdr_done   = (key_idx_inc == 2'd0);
         end
         PH_PAYLOAD: begin
            key_idx_in  = key_idx_inc;
            pay_left_in = pay_left_ff - {{(LEN_W-1){1'b0}}, 1'b1};
            res_valid   = 1'b1;
            res_item.item_kind     = KIND_PAYLOAD;
            res_item.data_byte     = in_byte ^ key_byte;
            res_item.last_of_frame = (pay_left_ff == {{(LEN_W-1){1'b0}}, 1'b1});
            if (res_item.last_of_frame) begin
               phase_in = PH_BYTE0;
            end
         end
         PH_ERROR: begin
            phase_in = PH_ERROR;
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // length known: limit check, then key or header
      if (len_done) begin
         hdr_len = len_value[LEN_W-1:0];
         if (over) begin
            phase_in  = PH_ERROR;
            res_valid = 1'b1;
            res_item.item_kind     = KIND_ERROR;
            res_item.last_of_frame = 1'b1;
         end else if (masked_in) begin
            phase_in   = PH_KEY;
            key_idx_in = 2'd0;
            key_in     = '0;
         end else begin
            key_in   = '0;
            hdr_done = 1'b1;
         end
      end

      // header complete: emit the header item
      if (hdr_done) begin
         pay_left_in = hdr_len;
         key_idx_in  = 2'd0;
         res_valid   = 1'b1;
         res_item.item_kind = KIND_HEADER;
         if (hdr_len == '0) begin
            phase_in = PH_BYTE0;
            res_item.last_of_frame = 1'b1;
         end else begin
            phase_in = PH_PAYLOAD;
            res_item.frame_length = hdr_len;
         end
      end

      res_item.final_fragment = fin_in;
      res_item.frame_opcode   = opcode_in;
      res_item.was_masked     = masked_in;
      res_valid               = res_valid && in_fire;
   end

   // state registers, advanced on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_BYTE0;
         fin_ff      <= 1'b0;
         opcode_ff   <= '0;
         masked_ff   <= 1'b0;
         acc_ff      <= '0;
         len_left_ff <= '0;
         key_ff      <= '0;
         key_idx_ff  <= '0;
         pay_left_ff <= '0;
      end else if (in_fire) begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         masked_ff   <= masked_in;
         acc_ff      <= acc_in;
         len_left_ff <= len_left_in;
         key_ff      <= key_in;
         key_idx_ff  <= key_idx_in;
         pay_left_ff <= pay_left_in;
      end
   end

endmodule

### hdl/wsd_skid.sv
// ----------------------------------------------------------------------------
// wsd_skid
// Result register with a skid stage, so input keeps flowing for one stall.
// ----------------------------------------------------------------------------
module wsd_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wsd_pkg::rsp_item_type  push_item,
   output logic                   can_push,
   wsd_rsp_if.source              rsp
);
   import wsd_pkg::*;

   logic         out_valid_ff,  out_valid_in;
   rsp_item_type out_item_ff,   out_item_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type skid_item_ff,  skid_item_in;
   logic         out_fire;

   assign out_fire = out_valid_ff && rsp.ready;
   assign can_push = !skid_valid_ff;

   // fill and drain
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || out_fire) begin
            out_valid_in = 1'b1;
            out_item_in  = push_item;
         end else begin
            skid_valid_in = 1'b1;
            skid_item_in  = push_item;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   // result channel
   assign rsp.valid          = out_valid_ff;
   assign rsp.item_kind      = out_item_ff.item_kind;
   assign rsp.final_fragment = out_item_ff.final_fragment;
   assign rsp.frame_opcode   = out_item_ff.frame_opcode;
   assign rsp.was_masked     = out_item_ff.was_masked;
   assign rsp.frame_length   = out_item_ff.frame_length;
   assign rsp.data_byte      = out_item_ff.data_byte;
   assign rsp.last_of_frame  = out_item_ff.last_of_frame;

endmodule

### hdl/websocket_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side websocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
// Usage:
//   req carries the received stream, one byte per item. rsp carries result
//   items: one header item per frame once its header (and key, if masked) is
//   in, then one unmasked payload item per payload byte; the last item of a
//   frame has last_of_frame set. A frame longer than the csr limit
//   (register 0 at byte address 0) gives one error item, and all later bytes
//   are swallowed until reset.
//   Throughput is one byte per cycle while req.ready is high: the parser
//   state advances in the same cycle that a byte is taken. A result is held
//   in the result register, or in the skid stage while rsp stalls.
//   Reset returns the parser to the first header byte, empties the result
//   register and restores the limit to 10 MiB.
//   When rsp stalls, a skid stage takes one more result, then req.ready
//   drops until the receiver takes items again; bytes that cause no result
//   are still only accepted while req.ready is high.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit (
   input  logic                            clock,
   input  logic                            reset,
   wsd_req_if.sink                         req,
   wsd_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wsd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wsd_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wsd_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import wsd_pkg::*;

   logic             in_fire;
   logic             can_push;
   logic             res_valid;
   rsp_item_type     res_item;
   logic [LEN_W-1:0] max_len;

   assign req.ready = can_push;
   assign in_fire   = req.valid && can_push;

   // configuration
   wsd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_len     (max_len)
   );

   // frame parser
   wsd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_byte   (req.stream_byte),
      .max_len   (max_len),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   // result register and skid stage
   wsd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res_item),
      .can_push  (can_push),
      .rsp       (rsp)
   );

endmodule
